// File: rtl/pipg_pkg.sv
// ----------------------------------------------------------------------------
// pipg_pkg
// Shared types and constants for the point-in-polygon gate: register codes,
// controller states and the controller-to-datapath command word.
// ----------------------------------------------------------------------------
package pipg_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_COORD_WIDTH  = 16;

    // Fixed field widths
    localparam int CNT_W       = 7;
    localparam int SLOT_W      = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_ENABLE  = 1'b1;

    // Input op codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT
    } pipg_state_t;

    typedef enum logic [1:0] {
        RES_PARITY,
        RES_ONE,
        RES_ZERO
    } res_sel_t;

    typedef struct packed {
        logic     wr_en;       // write the input vertex into the table
        logic     load_point;  // latch the test point, clear the crossing parity
        logic     rd_en;       // read one table entry
        logic     rd_first;    // entry read is vertex 0: no edge ends there
        logic     emit;        // present a result word next cycle
        res_sel_t emit_sel;
    } pipg_cmd_t;

endpackage

// File: rtl/point_in_polygon_gate.sv
// ----------------------------------------------------------------------------
// point_in_polygon_gate
// Even-odd ray-crossing test of a point against a stored polygon gate.
// ----------------------------------------------------------------------------
// A word with op=0 stores one vertex and gives no result; busy stays low. A
// word with op=1 tests a point and gives exactly one result, shown on
// inside_res for one cycle with done high; the receiver cannot hold it off.
// With the gate disabled, or fewer than two vertices in use, the result
// comes on the cycle after start and busy stays low. Otherwise busy is high
// through the walk, drain and emit states, and done rises in the first cycle
// with busy low: the walk reads one vertex per cycle from the single-port
// vertex table, and a three-stage edge pipeline (read, cross products,
// compare) drains behind it. The vertex table holds no reset value; load
// every vertex in use first.
// ----------------------------------------------------------------------------
module point_in_polygon_gate
    import pipg_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [SLOT_W-1:0]             vertex_index,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    output logic                          done,
    output logic                          inside_res
);

    localparam int AW = $clog2(MAX_VERTICES);

    pipg_cmd_t      cmd;
    logic [AW-1:0]  rd_addr;

    pipg_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .op           (op),
        .vertex_index (vertex_index),
        .busy         (busy),
        .cmd          (cmd),
        .rd_addr      (rd_addr)
    );

    pipg_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH),
        .AW           (AW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .vertex_index (vertex_index),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .done         (done),
        .inside_res   (inside_res)
    );

    // A vertex load never produces a result word
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_LOAD)) |=> !done)
        else $error("result word after a vertex load");

    // Results appear only once the walk is over
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while the edge walk is running");

    // A walk starts only from an accepted test
    a_walk_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (op == OP_TEST)))
        else $error("edge walk started without a test word");

endmodule

// File: rtl/pipg_ctrl.sv
// ----------------------------------------------------------------------------
// pipg_ctrl
// Controller: configuration registers, command decode and the edge walk
// sequencer that steps the vertex table read address.
// ----------------------------------------------------------------------------
module pipg_ctrl
    import pipg_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int AW           = $clog2(DEF_MAX_VERTICES)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    input  logic                  op,
    input  logic [SLOT_W-1:0]     vertex_index,
    output logic                  busy,
    output pipg_cmd_t             cmd,
    output logic [AW-1:0]         rd_addr
);

    localparam int CW = (AW > CNT_W) ? AW : CNT_W;

    pipg_state_t       state_reg, state_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              drain_reg, drain_next;
    logic [CNT_W-1:0]  count_reg;
    logic              gate_en_reg;
    logic              accept;
    logic              walk_last;
    logic              slot_ok;
    logic              few_vertices;

    assign accept       = start && (state_reg == ST_IDLE);
    assign walk_last    = ((idx_reg + CW'(1)) == CW'(count_reg));
    assign slot_ok      = (32'(vertex_index) < 32'(MAX_VERTICES));
    assign few_vertices = (count_reg < CNT_W'(2));
    assign busy         = (state_reg != ST_IDLE);
    assign rd_addr      = idx_reg[AW-1:0];

    // Configuration registers; count saturates at the table depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            gate_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VERTEX_COUNT:
                begin
                    if (32'(cfg_data) > 32'(MAX_VERTICES))
                        count_reg <= CNT_W'(MAX_VERTICES);
                    else
                        count_reg <= cfg_data;
                end
                CFG_GATE_ENABLE: gate_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            drain_reg <= drain_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        drain_next = drain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (accept && (op == OP_TEST) && gate_en_reg && !few_vertices)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                idx_next = idx_reg + CW'(1);
                if (walk_last)
                begin
                    state_next = ST_DRAIN;
                    drain_next = 1'b0;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last edge to leave the datapath pipeline
                drain_next = 1'b1;
                if (drain_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        cmd.emit_sel = RES_PARITY;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_LOAD)
                        cmd.wr_en = slot_ok;
                    else if (!gate_en_reg)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = RES_ONE;
                    end
                    else if (few_vertices)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = RES_ZERO;
                    end
                    else
                        cmd.load_point = 1'b1;
                end
            end
            ST_WALK:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (idx_reg == '0);
            end
            ST_DRAIN: ;
            ST_EMIT:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = RES_PARITY;
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/pipg_datapath.sv
// ----------------------------------------------------------------------------
// pipg_datapath
// Vertex table memory and the edge pipeline: table read, straddle check
// with cross products, then compare and crossing parity.
// ----------------------------------------------------------------------------
module pipg_datapath
    import pipg_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH,
    parameter int AW           = $clog2(DEF_MAX_VERTICES)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pipg_cmd_t                     cmd,
    input  logic [AW-1:0]                 rd_addr,
    input  logic [SLOT_W-1:0]             vertex_index,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    output logic                          done,
    output logic                          inside_res
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;

    logic [2*W-1:0]        mem [MAX_VERTICES];
    logic [2*W-1:0]        rdata_reg;
    logic [2*W-1:0]        prev_reg;
    logic                  rd_v_reg;
    logic                  rd_first_reg;
    logic signed [W-1:0]   px_reg, py_reg;
    logic signed [PW-1:0]  p1_reg, p2_reg;
    logic                  neg_reg;
    logic                  ev_reg;
    logic                  parity_reg;
    logic                  done_reg;
    logic                  res_reg;

    logic signed [W-1:0]   x0, y0, x1, y1;
    logic signed [DW-1:0]  dx_p, dy_p, dx_e, dy_e;
    logic                  straddle;
    logic                  edge_ok;
    logic                  right;
    logic                  res_val;

    assign x0 = prev_reg[2*W-1:W];
    assign y0 = prev_reg[W-1:0];
    assign x1 = rdata_reg[2*W-1:W];
    assign y1 = rdata_reg[W-1:0];

    assign dx_p = DW'(px_reg) - DW'(x0);
    assign dy_p = DW'(py_reg) - DW'(y0);
    assign dx_e = DW'(x1) - DW'(x0);
    assign dy_e = DW'(y1) - DW'(y0);

    // Half-open rule: y0 < py <= y1 or y1 < py <= y0
    assign straddle = !((py_reg <= y0) && (py_reg <= y1)) &&
                      !((y0 < py_reg) && (y1 < py_reg));
    assign edge_ok  = rd_v_reg && !rd_first_reg && (dy_e != '0) && straddle;

    // Flip the compare when the edge runs downward
    assign right = neg_reg ? (p2_reg < p1_reg) : (p1_reg < p2_reg);

    always_comb
    begin
        case (cmd.emit_sel)
            RES_PARITY: res_val = parity_reg;
            RES_ONE:    res_val = 1'b1;
            RES_ZERO:   res_val = 1'b0;
            default:    res_val = 1'b0;
        endcase
    end

    // Vertex table
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[AW'(vertex_index)] <= {x_coord, y_coord};
        if (cmd.rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_point)
        begin
            px_reg <= x_coord;
            py_reg <= y_coord;
        end
        if (rd_v_reg)
            prev_reg <= rdata_reg;
        p1_reg  <= PW'(dx_p) * PW'(dy_e);
        p2_reg  <= PW'(dy_p) * PW'(dx_e);
        neg_reg <= dy_e[DW-1];
        if (cmd.emit)
            res_reg <= res_val;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg     <= 1'b0;
            rd_first_reg <= 1'b0;
            ev_reg       <= 1'b0;
            parity_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rd_v_reg     <= cmd.rd_en;
            rd_first_reg <= cmd.rd_first;
            ev_reg       <= edge_ok;
            done_reg     <= cmd.emit;
            if (cmd.load_point)
                parity_reg <= 1'b0;
            else if (ev_reg && right)
                parity_reg <= !parity_reg;
        end
    end

    assign done       = done_reg;
    assign inside_res = res_reg;

endmodule

// File: verif/point_in_polygon_gate_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_gate_tb
// Self-checking bench for the polygon gate. A scoreboard class keeps its own
// vertex table and register copies, works out the even-odd crossing parity
// of every accepted test word, and checks each done strobe against the oldest
// pending answer. Stimulus is a short directed pass over edge and vertex
// hits, then random polygons (tiny, medium, full-range, extreme corners;
// closed or open) loaded through the command port and probed with points.
// ----------------------------------------------------------------------------
module point_in_polygon_gate_tb;
    import pipg_pkg::*;

    localparam int NV           = DEF_MAX_VERTICES;
    localparam int CW           = DEF_COORD_WIDTH;
    localparam int RANDOM_WORDS = 800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = NV + 16;
    localparam int COORD_MIN    = -32768;
    localparam int COORD_MAX    = 32767;

    class gate_scoreboard;
        logic signed [CW-1:0] table_x [NV];
        logic signed [CW-1:0] table_y [NV];
        int unsigned          vcount;
        bit                   enable;
        bit                   inside_expected [$];
        int unsigned          failures;
        int unsigned          loads;
        int unsigned          tests;
        int unsigned          checked;

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_VERTEX_COUNT: vcount = (data > NV) ? NV : data;
                CFG_GATE_ENABLE:  enable = data[0];
                default: ;
            endcase
        endfunction

        // even-odd count of edges crossing the ray to the right of the point
        function bit point_inside(logic signed [CW-1:0] px, logic signed [CW-1:0] py);
            longint x0, y0, x1, y1, dy, lpx, lpy, lhs, rhs;
            bit     parity;
            if (!enable)
                return 1'b1;
            parity = 1'b0;
            lpx = px;
            lpy = py;
            for (int i = 0; i + 1 < vcount; i++)
            begin
                x0 = table_x[i];
                y0 = table_y[i];
                x1 = table_x[i+1];
                y1 = table_y[i+1];
                dy = y1 - y0;
                if (dy == 0)
                    continue;
                if (lpy <= y0 && lpy <= y1)
                    continue;
                if (y0 < lpy && y1 < lpy)
                    continue;
                // px < x0 + (py-y0)*(x1-x0)/dy, scaled by dy
                lhs = (lpx - x0) * dy;
                rhs = (lpy - y0) * (x1 - x0);
                if ((dy > 0) ? (lhs < rhs) : (rhs < lhs))
                    parity = ~parity;
            end
            return parity;
        endfunction

        function void note_word(logic o, logic [SLOT_W-1:0] slot,
                                logic signed [CW-1:0] x, logic signed [CW-1:0] y);
            if (o == OP_LOAD)
            begin
                loads++;
                if (slot < NV)
                begin
                    table_x[slot] = x;
                    table_y[slot] = y;
                end
            end
            else
            begin
                tests++;
                inside_expected = {inside_expected, point_inside(x, y)};
            end
        endfunction

        function void check_result(logic actual);
            bit exp_inside;
            if (inside_expected.size() == 0)
            begin
                $error("inside_res: result with no pending test, actual %0d", actual);
                failures++;
                return;
            end
            exp_inside = inside_expected.pop_front();
            checked++;
            if (actual !== exp_inside)
            begin
                $error("inside_res mismatch: expected %0d, actual %0d", exp_inside, actual);
                failures++;
            end
        endfunction

        function int pending();
            return inside_expected.size();
        endfunction

        function void close_out();
            if (inside_expected.size() != 0)
            begin
                $error("inside_res: %0d expected results never arrived", inside_expected.size());
                failures++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   start;
    logic                   busy;
    logic                   op;
    logic [SLOT_W-1:0]      vertex_index;
    logic signed [CW-1:0]   x_coord;
    logic signed [CW-1:0]   y_coord;
    logic                   done;
    logic                   inside_res;

    gate_scoreboard sb;
    int unsigned    cycle_count;
    int unsigned    words_sent;
    int unsigned    cfg_writes;
    int unsigned    phases;
    int             burst_left;
    int             shape_x [NV];
    int             shape_y [NV];

    point_in_polygon_gate dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .vertex_index (vertex_index),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .done         (done),
        .inside_res   (inside_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // sample everything on the rising edge, before the block's own updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(inside_res);
            if (cfg_we)
                sb.set_register(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_word(op, vertex_index, x_coord, y_coord);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("point_in_polygon_gate verification failed");
            $finish;
        end
    end

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clip16(int v);
        return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    // mode 0/1: box around a center, 2: anywhere, 3: mostly range extremes
    function automatic int gen_coord(int mode, int center, int half);
        case (mode)
            2: return pick(COORD_MIN, COORD_MAX);
            3:
            begin
                case ($urandom_range(0, 4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return COORD_MIN + 1;
                    3: return COORD_MAX - 1;
                    default: return pick(COORD_MIN, COORD_MAX);
                endcase
            end
            default: return clip16(center + pick(-half, half));
        endcase
    endfunction

    task automatic send_word(input logic o, input int slot, input int x, input int y);
        @(negedge clk);
        start        <= 1'b1;
        op           <= o;
        vertex_index <= slot[SLOT_W-1:0];
        x_coord      <= x[CW-1:0];
        y_coord      <= y[CW-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (pick(0, 7))
                @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? pick(20, 60) : pick(1, 8);
        end
    endtask

    task automatic load_vertex(input int slot, input int x, input int y);
        send_word(OP_LOAD, slot, x, y);
    endtask

    task automatic test_point(input int x, input int y);
        send_word(OP_TEST, pick(0, NV - 1), x, y);
    endtask

    // hold start low until every result is in and a load has surely landed
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    task automatic run_phase();
        int  k, mode, half, cx, cy, n, v, px, py, slot;
        int  xmin, xmax, ymin, ymax;
        bit  closed, reverse;
        case ($urandom_range(0, 9))
            0: k = pick(0, 1);
            1: k = NV;
            default: k = pick(2, 12);
        endcase
        mode   = pick(0, 3);
        half   = (mode == 0) ? pick(1, 8) : pick(50, 3000);
        cx     = pick(-30000, 30000);
        cy     = pick(-30000, 30000);
        closed = ($urandom_range(0, 3) != 0);
        xmin = COORD_MAX;
        xmax = COORD_MIN;
        ymin = COORD_MAX;
        ymax = COORD_MIN;
        for (int i = 0; i < k; i++)
        begin
            shape_x[i] = gen_coord(mode, cx, half);
            shape_y[i] = gen_coord(mode, cy, half);
            if (closed && k >= 2 && i == k - 1)
            begin
                shape_x[i] = shape_x[0];
                shape_y[i] = shape_y[0];
            end
            if (shape_x[i] < xmin) xmin = shape_x[i];
            if (shape_x[i] > xmax) xmax = shape_x[i];
            if (shape_y[i] < ymin) ymin = shape_y[i];
            if (shape_y[i] > ymax) ymax = shape_y[i];
        end
        if (k == 0)
        begin
            xmin = COORD_MIN;
            xmax = COORD_MAX;
            ymin = COORD_MIN;
            ymax = COORD_MAX;
        end
        xmin = clip16(xmin - 2);
        xmax = clip16(xmax + 2);
        ymin = clip16(ymin - 2);
        ymax = clip16(ymax + 2);

        reverse = $urandom_range(0, 1);
        for (int i = 0; i < k; i++)
        begin
            v = reverse ? k - 1 - i : i;
            load_vertex(v, shape_x[v], shape_y[v]);
            if (k < NV && $urandom_range(0, 5) == 0)
                load_vertex(pick(k, NV - 1), pick(COORD_MIN, COORD_MAX),
                            pick(COORD_MIN, COORD_MAX));
        end

        settle();
        write_reg(CFG_VERTEX_COUNT, (k == NV && $urandom_range(0, 1)) ? pick(NV, 127) : k);
        write_reg(CFG_GATE_ENABLE, (pick(0, 63) << 1) | int'($urandom_range(0, 5) != 0));
        phases++;

        n = pick(15, 45);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // reshape a vertex in use or scribble on a spare slot
                slot = pick(0, NV - 1);
                px   = gen_coord(mode, cx, half);
                py   = gen_coord(mode, cy, half);
                if (slot < k)
                begin
                    shape_x[slot] = px;
                    shape_y[slot] = py;
                end
                load_vertex(slot, px, py);
            end
            else
            begin
                v  = (k > 0) ? pick(0, k - 1) : 0;
                px = pick(xmin, xmax);
                py = pick(ymin, ymax);
                if (k > 0)
                begin
                    case ($urandom_range(0, 5))
                        0:
                        begin
                            px = shape_x[v];
                            py = shape_y[v];
                        end
                        1: py = shape_y[v];
                        2: px = shape_x[v];
                        3:
                        begin
                            px = pick(COORD_MIN, COORD_MAX);
                            py = pick(COORD_MIN, COORD_MAX);
                        end
                        default: ;
                    endcase
                end
                test_point(px, py);
            end
        end
    endtask

    initial
    begin
        int directed_words;
        sb           = new;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_VERTEX_COUNT;
        cfg_data     = '0;
        start        = 1'b0;
        op           = OP_LOAD;
        vertex_index = '0;
        x_coord      = '0;
        y_coord      = '0;
        cycle_count  = 0;
        words_sent   = 0;
        cfg_writes   = 0;
        phases       = 0;
        burst_left   = 0;
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;

        // gate off after reset: any point passes
        test_point(COORD_MIN, COORD_MAX);
        settle();
        write_reg(CFG_GATE_ENABLE, 1);
        // no vertices in use
        test_point(0, 0);

        // closed square
        load_vertex(0, -100, -100);
        load_vertex(1, 100, -100);
        load_vertex(2, 100, 100);
        load_vertex(3, -100, 100);
        load_vertex(4, -100, -100);
        settle();
        write_reg(CFG_VERTEX_COUNT, 1);
        test_point(0, 0);
        settle();
        write_reg(CFG_VERTEX_COUNT, 5);
        test_point(0, 0);
        test_point(200, 0);
        test_point(-100, 0);
        test_point(100, 0);
        test_point(0, 100);
        test_point(0, -100);
        test_point(-100, -100);
        test_point(100, 100);
        test_point(COORD_MIN, 0);
        test_point(COORD_MAX, COORD_MAX);
        // open polygon: no closing edge
        settle();
        write_reg(CFG_VERTEX_COUNT, 4);
        test_point(0, 0);

        // full-range triangle, plus the top slot at the extremes
        load_vertex(0, COORD_MIN, COORD_MIN);
        load_vertex(1, COORD_MAX, COORD_MIN);
        load_vertex(2, COORD_MAX, COORD_MAX);
        load_vertex(3, COORD_MIN, COORD_MIN);
        load_vertex(NV - 1, COORD_MAX, COORD_MIN);
        settle();
        test_point(0, 0);
        test_point(COORD_MAX, 0);
        test_point(COORD_MIN, COORD_MAX);
        directed_words = words_sent;

        while (words_sent - directed_words < RANDOM_WORDS)
            run_phase();

        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        sb.close_out();

        $display("Covered %0d vertex loads and %0d point tests across %0d random polygons,",
                 sb.loads, sb.tests, phases);
        $display("%0d register writes, %0d results checked in %0d cycles.",
                 cfg_writes, sb.checked, cycle_count);
        if (sb.failures == 0)
            $display("point_in_polygon_gate verification clean");
        else
            $display("point_in_polygon_gate verification failed");
        $finish;
    end

endmodule
